FILE: hdl/pntt_pkg.sv
// Shared types and constants of the periodic notify timer table.
package pntt_pkg;

  // Cap on fired results reported per tick
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] TICK_PERIOD_RESET = 16'd10;

  // Request codes
  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_CLEAR    = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_TICK     = 2'd3
  } req_t;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_PARAM_ERR = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Config register indexes (word address)
  localparam logic REG_TICK_PERIOD = 1'b0;

  // One table entry as stored in memory
  typedef struct packed {
    logic [15:0] client;
    logic [30:0] interval;
    logic [31:0] elapsed;
  } entry_t;

endpackage

FILE: hdl/pntt_mem.sv
// Entry memory: one write port, one read port, registered read data.
module pntt_mem
  import pntt_pkg::*;
#(
  parameter int  MAX_ENTRIES = 16,
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata
);

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pntt_cfg.sv
// APB configuration register: tick period.
module pntt_cfg
  import pntt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] tick_period_ms
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TICK_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= TICK_PERIOD_RESET;
    end else if (wr_en) begin
      tick_period_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TICK_PERIOD) begin
      prdata = {16'd0, tick_period_ms};
    end
  end

endmodule

FILE: hdl/pntt_ctrl.sv
// Request sequencer: walks the entry memory, read-modify-write, builds results.
module pntt_ctrl
  import pntt_pkg::*;
#(
  parameter int  MAX_ENTRIES = 16,
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [15:0]        client_id,
  input  logic signed [31:0] interval_ms,
  input  logic               suspended,
  input  logic [15:0]        tick_period_ms,
  output logic               rd_en,
  output logic [AW-1:0]      raddr,
  input  entry_t             rdata,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output entry_t             wdata,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic               running,
  output logic               fired,
  output logic [15:0]        fired_client,
  output logic               last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state;
  req_t                req;
  logic [15:0]         id;
  logic [30:0]         ivl;
  logic [CW-1:0]       count;
  logic [CW-1:0]       iss;
  logic                pv;
  logic [AW-1:0]       pidx;
  logic                found;
  logic                held_vld;
  logic [15:0]         held_client;
  logic [NRES_W-1:0]   nres;

  logic        accept;
  logic        bad_reg;
  logic        quick;
  logic        scan_end;
  logic        has_room;
  logic [32:0] sum;
  logic [31:0] elapsed_sat;
  logic        due;
  logic        match;
  logic        report;

  assign busy     = (state == S_SCAN);
  assign accept   = start && (state == S_IDLE);
  assign bad_reg  = (req_type == REQ_REGISTER) &&
                    ((client_id == 16'd0) || interval_ms[31] || (interval_ms == 32'sd0));
  assign quick    = bad_reg || ((req_type == REQ_TICK) && suspended);
  assign has_room = (count < CW'(MAX_ENTRIES));

  assign rd_en    = (state == S_SCAN) && (iss < count);
  assign raddr    = iss[AW-1:0];
  assign scan_end = (state == S_SCAN) && !pv && (iss == count);

  // per-entry datapath; elapsed saturates at all ones
  assign sum         = {1'b0, rdata.elapsed} + {17'd0, tick_period_ms};
  assign elapsed_sat = sum[32] ? '1 : sum[31:0];
  assign due         = ({1'b0, rdata.interval} <= elapsed_sat);
  assign match       = (rdata.client == id) && (id != 16'd0);
  assign report      = pv && (req == REQ_TICK) && due && (nres < NRES_W'(MAX_RESULTS));

  // write port: tick update, clear shift-down, register append
  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wdata = rdata;
    if (state == S_SCAN && pv) begin
      if (req == REQ_TICK) begin
        we    = 1'b1;
        wdata = {rdata.client, rdata.interval, (due ? 32'd0 : elapsed_sat)};
      end else if (req == REQ_CLEAR && found) begin
        we    = 1'b1;
        waddr = pidx - AW'(1);
      end
    end
    if (scan_end && req == REQ_REGISTER && !found && has_room) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = {id, ivl, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req      <= req_t'(req_type);
            id       <= client_id;
            ivl      <= interval_ms[30:0];
            iss      <= '0;
            pv       <= 1'b0;
            found    <= 1'b0;
            held_vld <= 1'b0;
            nres     <= '0;
            if (quick) begin
              result_valid <= 1'b1;
              status       <= bad_reg ? STATUS_PARAM_ERR : STATUS_OK;
              running      <= 1'b0;
              fired        <= 1'b0;
              fired_client <= 16'd0;
              last         <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pv   <= rd_en;
          pidx <= iss[AW-1:0];
          if (rd_en) begin
            iss <= iss + CW'(1);
          end
          if (pv && req != REQ_TICK && match) begin
            found <= 1'b1;
          end
          // a fired entry is held until the next one shows it was not the last
          if (report) begin
            if (held_vld) begin
              result_valid <= 1'b1;
              status       <= STATUS_OK;
              running      <= 1'b0;
              fired        <= 1'b1;
              fired_client <= held_client;
              last         <= 1'b0;
            end
            held_vld    <= 1'b1;
            held_client <= rdata.client;
            nres        <= nres + NRES_W'(1);
          end
          if (scan_end) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
            status       <= STATUS_OK;
            running      <= 1'b0;
            fired        <= 1'b0;
            fired_client <= 16'd0;
            last         <= 1'b1;
            case (req)
              REQ_REGISTER: begin
                if (!found) begin
                  if (has_room) begin
                    count <= count + CW'(1);
                  end else begin
                    status <= STATUS_FULL;
                  end
                end
              end
              REQ_CLEAR: begin
                if (found) begin
                  count <= count - CW'(1);
                end
              end
              REQ_QUERY: begin
                running <= found;
              end
              default: begin
                if (held_vld) begin
                  fired        <= 1'b1;
                  fired_client <= held_client;
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/periodic_notify_timer_table_top.sv
// Top level of the periodic notify timer table.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. req_type selects register, clear, query or tick; client_id,
// interval_ms and suspended go with it.
// Result channel: each result sits on status/running/fired/fired_client/last
// for exactly one cycle, flagged by result_valid. The receiver cannot stall.
// Register, clear and query give one result; a tick gives one result per
// fired entry in table order (at most 16), or one empty result, and the
// final result of every request has last high.
// Timing: a register with bad parameters or a suspended tick answers the
// cycle after acceptance and never raises busy. All other requests walk the
// entry memory, one entry per cycle through its single read port with
// registered read data; busy stays high for the whole walk over the clients
// in the table, and the final result appears in the cycle busy drops. A due
// entry is reported once the next due entry or the end of the walk shows
// whether it is last. Config: APB port, tick_period_ms at byte address 0,
// written by the user only while idle; the block does not enforce this.
// Reset (synchronous, rst high) empties the table and sets the tick period
// to 10 ms; memory contents are not cleared, the fill count guards them.
module periodic_notify_timer_table_top
  import pntt_pkg::*;
#(
  parameter int  MAX_ENTRIES = 16,
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [15:0]        client_id,
  input  logic signed [31:0] interval_ms,
  input  logic               suspended,
  // result channel
  output logic               result_valid,
  output logic [1:0]         status,
  output logic               running,
  output logic               fired,
  output logic [15:0]        fired_client,
  output logic               last,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]   tick_period_ms;
  logic          rd_en;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  pntt_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .tick_period_ms (tick_period_ms)
  );

  // table storage: client, interval and elapsed time per entry
  pntt_mem #(.MAX_ENTRIES(MAX_ENTRIES)) u_mem (
    .clk   (clk),
    .rd_en (rd_en),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // sequencer: one entry per cycle; writes trail reads so they never collide
  pntt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .client_id      (client_id),
    .interval_ms    (interval_ms),
    .suspended      (suspended),
    .tick_period_ms (tick_period_ms),
    .rd_en          (rd_en),
    .raddr          (raddr),
    .rdata          (rdata),
    .we             (we),
    .waddr          (waddr),
    .wdata          (wdata),
    .result_valid   (result_valid),
    .status         (status),
    .running        (running),
    .fired          (fired),
    .fired_client   (fired_client),
    .last           (last)
  );

endmodule

FILE: hdl/pntt_chk.sv
// Port-level checker for the timer table, bound to the top level.
module pntt_chk
  import pntt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [1:0]  status,
  input logic        running,
  input logic        fired,
  input logic        last
);

  // an accepted request either starts a walk or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst || $past(rst))
    start && !busy |=> busy || (result_valid && last))
    else $error("accepted request neither walked nor answered");

  // the end of a walk always carries the final result
  a_walk_end: assert property (@(posedge clk) disable iff (rst || $past(rst))
    $fell(busy) |-> result_valid && last)
    else $error("walk ended without final result");

  // a notification carries no error and no query answer
  a_fired_clean: assert property (@(posedge clk) disable iff (rst || $past(rst))
    result_valid && fired |-> (status == STATUS_OK) && !running)
    else $error("fired result with status or running set");

  // a query answer is a single final result
  a_running_last: assert property (@(posedge clk) disable iff (rst || $past(rst))
    result_valid && running |-> last && !fired && !busy)
    else $error("running set outside a final query result");

endmodule

bind periodic_notify_timer_table_top pntt_chk u_pntt_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .running      (running),
  .fired        (fired),
  .last         (last)
);
